@@ rtl/q24_8_fixed_point_alu_top_macros.svh @@
// assertion macros for the fixed-point alu
`ifndef Q24_8_FIXED_POINT_ALU_TOP_MACROS_SVH
`define Q24_8_FIXED_POINT_ALU_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define QALU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qalu check failed");
// implication whose consequent is checked in the cycle after the antecedent
`define QALU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qalu check failed");
`endif

@@ rtl/qalu_pkg.sv @@
// types and operation codes for the fixed-point alu
package qalu_pkg;
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_INC = 4'd4;
    localparam logic [3:0] OP_DEC = 4'd5;
    localparam logic [3:0] OP_MIN = 4'd6;
    localparam logic [3:0] OP_MAX = 4'd7;
    localparam logic [3:0] OP_TOI = 4'd8;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_greater;
        logic               a_less;
        logic               operands_equal;
        logic               divide_by_zero;
        logic               overflowed;
    } out_word_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [3:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic        neg;
        logic        b_zero;
        logic        gt;
        logic        lt;
        logic        eq;
        logic signed [31:0] simple;
        logic        simple_ovf;
    } cls_t;
endpackage

@@ rtl/qalu_if.sv @@
// valid/ready channel interfaces for the alu
interface qalu_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, operation, operand_a, operand_b, input ready);
    modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface qalu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               a_greater;
    logic               a_less;
    logic               operands_equal;
    logic               divide_by_zero;
    logic               overflowed;
    modport source (output valid, result_value, a_greater, a_less, operands_equal,
                    divide_by_zero, overflowed, input ready);
    modport sink (input valid, result_value, a_greater, a_less, operands_equal,
                  divide_by_zero, overflowed, output ready);
endinterface

@@ rtl/qalu_front.sv @@
// front end: classifies an item and works out the simple operations
module qalu_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  qalu_pkg::in_word_t in_word,
    output logic              cls_valid,
    input  logic              cls_ready,
    output qalu_pkg::cls_t    cls_word
);
    import qalu_pkg::*;

    logic               valid_reg;
    cls_t               data_reg;
    cls_t               cls_next;
    logic signed [32:0] a_x;
    logic signed [32:0] b_x;
    logic signed [32:0] wide;
    logic               gt;
    logic               lt;

    assign a_x = {in_word.operand_a[31], in_word.operand_a};
    assign b_x = {in_word.operand_b[31], in_word.operand_b};
    assign gt  = in_word.operand_a > in_word.operand_b;
    assign lt  = in_word.operand_a < in_word.operand_b;

    always_comb
    begin
        unique case (in_word.operation)
            OP_ADD:  wide = a_x + b_x;
            OP_SUB:  wide = a_x - b_x;
            OP_INC:  wide = a_x + 33'sd1;
            OP_DEC:  wide = a_x - 33'sd1;
            OP_MIN:  wide = lt ? a_x : b_x;
            OP_MAX:  wide = gt ? a_x : b_x;
            OP_TOI:  wide = a_x >>> FRACTION_BITS;
            default: wide = '0;
        endcase
        cls_next.operation  = in_word.operation;
        cls_next.operand_a  = in_word.operand_a;
        cls_next.operand_b  = in_word.operand_b;
        cls_next.mag_a      = in_word.operand_a[31] ? 32'(-in_word.operand_a)
                                                    : in_word.operand_a;
        cls_next.mag_b      = in_word.operand_b[31] ? 32'(-in_word.operand_b)
                                                    : in_word.operand_b;
        cls_next.neg        = in_word.operand_a[31] ^ in_word.operand_b[31];
        cls_next.b_zero     = in_word.operand_b == '0;
        cls_next.gt         = gt;
        cls_next.lt         = lt;
        cls_next.eq         = in_word.operand_a == in_word.operand_b;
        cls_next.simple_ovf = wide[32] != wide[31];
        if (wide[32] != wide[31])
            cls_next.simple = wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            cls_next.simple = wide[31:0];
    end

    assign in_ready  = !valid_reg || cls_ready;
    assign cls_valid = valid_reg;
    assign cls_word  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= cls_next;
    end
endmodule

@@ rtl/qalu_queue.sv @@
// two-entry queue between front and back end
module qalu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  qalu_pkg::cls_t wr_word,
    output logic           rd_valid,
    input  logic           rd_ready,
    output qalu_pkg::cls_t rd_word
);
    import qalu_pkg::*;

    cls_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_word  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_word;
    end
endmodule

@@ rtl/qalu_back.sv @@
// back end: pipelined multiply and divide, result selection
module qalu_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cls_valid,
    output logic                cls_ready,
    input  qalu_pkg::cls_t      cls_word,
    output logic                out_valid,
    input  logic                out_ready,
    output qalu_pkg::out_word_t out_word
);
    import qalu_pkg::*;

    localparam int NW    = 32 + FRACTION_BITS + 1;   // 2n numerator width
    localparam int DW    = 34;                       // 2d and remainder width
    localparam int STG   = NW;                       // one quotient bit per stage
    localparam int DEPTH = STG + 2;

    typedef struct packed {
        cls_t            c;
        logic [63:0]     prod;
        logic [NW-1:0]   num;
        logic [DW-1:0]   rem;
        logic [NW-1:0]   quo;
    } stage_t;

    stage_t        st_reg [DEPTH];
    logic          v_reg  [DEPTH];
    stage_t        st_next [DEPTH];
    logic          adv;
    out_word_t     res_reg;
    logic          res_valid_reg;
    logic [63:0]   mq;
    logic [63:0]   dq;
    logic [64:0]   sq;
    logic          last_ovf;
    logic signed [31:0] last_val;
    cls_t          lc;

    // whole pipeline moves together; output register is the only hold point
    assign adv       = !res_valid_reg || out_ready;
    assign cls_ready = adv;
    assign out_valid = res_valid_reg;
    assign out_word  = res_reg;

    always_comb
    begin
        // stage 0: multiply and set up division
        st_next[0].c    = cls_word;
        st_next[0].prod = 64'(cls_word.mag_a) * 64'(cls_word.mag_b);
        st_next[0].num  = NW'({cls_word.mag_a, FRACTION_BITS'(0), 1'b0});
        st_next[0].rem  = '0;
        st_next[0].quo  = '0;
        // restoring division, one bit per stage, by 2d, with +d bias folded
        // into the numerator in stage 1
        st_next[1]      = st_reg[0];
        st_next[1].num  = st_reg[0].num + NW'(st_reg[0].c.mag_b);
        for (int i = 2; i < DEPTH; i++)
        begin
            logic [DW-1:0] r;
            logic [DW-1:0] d2;
            r  = {st_reg[i-1].rem[DW-2:0], st_reg[i-1].num[NW-1]};
            d2 = {1'b0, st_reg[i-1].c.mag_b, 1'b0};
            st_next[i]     = st_reg[i-1];
            st_next[i].num = st_reg[i-1].num << 1;
            if (r >= d2)
            begin
                st_next[i].rem = r - d2;
                st_next[i].quo = {st_reg[i-1].quo[NW-2:0], 1'b1};
            end
            else
            begin
                st_next[i].rem = r;
                st_next[i].quo = {st_reg[i-1].quo[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                v_reg[i] <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= cls_valid;
            for (int i = 1; i < DEPTH; i++)
                v_reg[i] <= v_reg[i-1];
            res_valid_reg <= v_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < DEPTH; i++)
                st_reg[i] <= st_next[i];
            res_reg <= {last_val, lc.gt, lc.lt, lc.eq,
                        (lc.operation == OP_DIV) && lc.b_zero, last_ovf};
        end
    end

    always_comb
    begin
        lc = st_reg[DEPTH-1].c;
        mq = (st_reg[DEPTH-1].prod + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        dq = 64'(st_reg[DEPTH-1].quo);
        unique case (lc.operation)
            OP_MUL:  sq = lc.neg ? 65'(0) - {1'b0, mq} : {1'b0, mq};
            OP_DIV:  sq = lc.neg ? 65'(0) - {1'b0, dq} : {1'b0, dq};
            default: sq = '0;
        endcase
        last_ovf = 1'b0;
        if (lc.operation == OP_MUL || (lc.operation == OP_DIV && !lc.b_zero))
        begin
            if (!lc.neg && sq > 65'h0_7fff_ffff)
            begin
                last_ovf = 1'b1;
                last_val = 32'sh7fff_ffff;
            end
            else if (lc.neg && sq[64] && sq < 65'h1_ffff_ffff_8000_0000)
            begin
                last_ovf = 1'b1;
                last_val = 32'sh8000_0000;
            end
            else
                last_val = sq[31:0];
        end
        else if (lc.operation == OP_DIV)
            last_val = lc.operand_a[31] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
        begin
            last_val = lc.simple;
            last_ovf = lc.simple_ovf;
        end
    end
endmodule

@@ rtl/q24_8_fixed_point_alu_top.sv @@
// top level of the signed fixed-point alu
//   channel | dir | payload
//   in      | in  | operation, operand_a, operand_b
//   out     | out | result_value, compare flags, divide_by_zero, overflowed
// one word per cycle sustained while the output channel accepts; the divider
// produces one quotient bit per stage.
// reset clears all valid flags; payload registers are not reset.
// a stall at the output holds the divider pipeline; the queue absorbs the
// front end, which then stalls once it fills.
module q24_8_fixed_point_alu_top #(
    parameter int FRACTION_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    qalu_in_if.sink    in_ch,
    qalu_out_if.source out_ch
);
    import qalu_pkg::*;

    in_word_t  in_word;
    out_word_t out_word;
    cls_t      f_word;
    cls_t      q_word;
    logic      f_valid;
    logic      f_ready;
    logic      q_valid;
    logic      q_ready;

    assign in_word = '{operation: in_ch.operation, operand_a: in_ch.operand_a,
                       operand_b: in_ch.operand_b};

    qalu_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_word(in_word), .cls_valid(f_valid), .cls_ready(f_ready), .cls_word(f_word));

    qalu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_word(f_word), .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word));

    qalu_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cls_valid(q_valid), .cls_ready(q_ready),
        .cls_word(q_word), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_word(out_word));

    assign out_ch.result_value   = out_word.result_value;
    assign out_ch.a_greater      = out_word.a_greater;
    assign out_ch.a_less         = out_word.a_less;
    assign out_ch.operands_equal = out_word.operands_equal;
    assign out_ch.divide_by_zero = out_word.divide_by_zero;
    assign out_ch.overflowed     = out_word.overflowed;
endmodule

@@ rtl/qalu_checker.sv @@
// port-level checks for the fixed-point alu
`include "q24_8_fixed_point_alu_top_macros.svh"
module qalu_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic a_greater,
    input logic a_less,
    input logic operands_equal,
    input logic divide_by_zero,
    input logic overflowed
);
    `QALU_ASSERT_IMP(flags_onehot, out_valid, $onehot({a_greater, a_less, operands_equal}))
    `QALU_ASSERT_IMP(dz_not_ovf, out_valid && divide_by_zero, !overflowed)
    `QALU_ASSERT_NEXT(out_held, out_valid && !out_ready, out_valid)
endmodule

bind q24_8_fixed_point_alu_top qalu_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .a_greater(out_ch.a_greater), .a_less(out_ch.a_less),
    .operands_equal(out_ch.operands_equal), .divide_by_zero(out_ch.divide_by_zero),
    .overflowed(out_ch.overflowed));

@@ tb/sv/tb_top.sv @@
// testbench for the fixed-point alu: random and directed words checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qalu_pkg::*;

    localparam int FB = 8;
    localparam int LATENCY = FB + 37;
    localparam longint LIMIT = 400000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;
    int errors = 0;

    qalu_in_if in_ch ();
    qalu_out_if out_ch ();

    q24_8_fixed_point_alu_top #(.FRACTION_BITS(FB)) i_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic longint sat(input longint v, inout logic ovf);
        if (v > VMAX)
        begin
            ovf = 1'b1;
            return VMAX;
        end
        if (v < VMIN)
        begin
            ovf = 1'b1;
            return VMIN;
        end
        return v;
    endfunction

    function automatic longint magn(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic out_word_t alu_predict(input in_word_t w);
        out_word_t o;
        longint a;
        longint b;
        longint r;
        logic ovf;
        logic dz;
        logic neg;
        longint unsigned p;
        longint unsigned n;
        longint unsigned d;
        a = w.operand_a;
        b = w.operand_b;
        r = 0;
        ovf = 1'b0;
        dz = 1'b0;
        neg = (a < 0) != (b < 0);
        case (w.operation)
            OP_ADD: r = sat(a + b, ovf);
            OP_SUB: r = sat(a - b, ovf);
            OP_MUL:
            begin
                p = magn(a) * magn(b);
                p = (p + (64'd1 << (FB - 1))) >> FB;
                r = sat(neg ? -longint'(p) : longint'(p), ovf);
            end
            OP_DIV:
                if (b == 0)
                begin
                    dz = 1'b1;
                    r = a < 0 ? VMIN : VMAX;
                end
                else
                begin
                    n = longint'(magn(a)) << FB;
                    d = magn(b);
                    p = (2 * n + d) / (2 * d);
                    r = sat(neg ? -longint'(p) : longint'(p), ovf);
                end
            OP_INC: r = sat(a + 1, ovf);
            OP_DEC: r = sat(a - 1, ovf);
            OP_MIN: r = a < b ? a : b;
            OP_MAX: r = a > b ? a : b;
            OP_TOI: r = a >>> FB;
            default: r = 0;
        endcase
        o.result_value = r[31:0];
        o.a_greater = a > b;
        o.a_less = a < b;
        o.operands_equal = a == b;
        o.divide_by_zero = dz;
        o.overflowed = ovf;
        return o;
    endfunction

    class alu_scoreboard;
        out_word_t pending[$];
        function void note_input(in_word_t w);
            pending.push_back(alu_predict(w));
        endfunction
        task check_result(out_word_t g);
            out_word_t e;
            if (pending.size() == 0)
            begin
                report("unexpected word", g.result_value, 0);
                return;
            end
            e = pending.pop_front();
            if (g.result_value !== e.result_value)
                report("result_value", g.result_value, e.result_value);
            if (g.a_greater !== e.a_greater) report("a_greater", g.a_greater, e.a_greater);
            if (g.a_less !== e.a_less) report("a_less", g.a_less, e.a_less);
            if (g.operands_equal !== e.operands_equal)
                report("operands_equal", g.operands_equal, e.operands_equal);
            if (g.divide_by_zero !== e.divide_by_zero)
                report("divide_by_zero", g.divide_by_zero, e.divide_by_zero);
            if (g.overflowed !== e.overflowed) report("overflowed", g.overflowed, e.overflowed);
        endtask
    endclass

    alu_scoreboard sb = new();

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.operation = OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // monitor: sample accepted words at the edge
    always @(posedge clk)
    begin
        out_word_t g;
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_input({in_ch.operation, in_ch.operand_a, in_ch.operand_b});
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            g.result_value = out_ch.result_value;
            g.a_greater = out_ch.a_greater;
            g.a_less = out_ch.a_less;
            g.operands_equal = out_ch.operands_equal;
            g.divide_by_zero = out_ch.divide_by_zero;
            g.overflowed = out_ch.overflowed;
            sb.check_result(g);
        end
    end

    // receiver stall pattern: phases of always-ready and random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if ((cycles / 700) % 3 == 0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    int gap_left = 0;

    // called just after a rising edge; valid stays high between words save random gaps
    task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        if (gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 6);
        while (gap_left > 0)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            gap_left--;
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // stop sending and wait for every expected word
    task automatic drain_all();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4095) - 2048;
            3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] ex[6];
        logic [3:0] op;
        ex = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h100, 32'hffffff00, 32'hffffffff};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: every operation on extremes, zero divisor, unknown codes
        for (int k = 0; k < 16; k++)
            send_word(4'(k), ex[k % 6], ex[(k + 2) % 6]);
        send_word(OP_DIV, 32'h0, 32'h0);
        send_word(OP_DIV, 32'h80000000, 32'h0);
        send_word(OP_DIV, 32'h180, 32'h100);
        send_word(OP_MUL, 32'h80000000, 32'h80000000);
        send_word(OP_MUL, 32'hffffff80, 32'h1);
        send_word(OP_MIN, 32'h1234, 32'h1234);
        send_word(OP_MAX, 32'h80000000, 32'h80000000);
        send_word(OP_TOI, 32'hffffffff, 32'h5a5a5a5a);
        // hold off until everything has drained
        drain_all();
        for (int i = 0; i < 1600; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            send_word(op, rand_operand(), ($urandom_range(0, 9) == 0) ? 32'h0 : rand_operand());
            if (i == 800)
                drain_all();
        end
        drain_all();
        repeat (LATENCY * 2) @(posedge clk);
        if (errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ q24_8_fixed_point_alu_top.f @@
+incdir+rtl
rtl/qalu_pkg.sv
rtl/qalu_if.sv
rtl/qalu_front.sv
rtl/qalu_queue.sv
rtl/qalu_back.sv
rtl/q24_8_fixed_point_alu_top.sv
rtl/qalu_checker.sv
tb/sv/tb_top.sv
